FILE: rtl/core/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg
// Shared constants and types of the four-channel FIR low-pass unit.
// ----------------------------------------------------------------------------
package fcfl_pkg;

	localparam int CHANNEL_COUNT = 4;
	localparam int COEF_W        = 16;
	localparam int FRAC_BITS     = 15;
	localparam int NUM_COEF_REGS = 6;
	localparam int CFG_INDEX_W   = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COEF_TAP0 = 3'd0,
		CFG_COEF_TAP1 = 3'd1,
		CFG_COEF_TAP2 = 3'd2,
		CFG_COEF_TAP3 = 3'd3,
		CFG_COEF_TAP4 = 3'd4,
		CFG_COEF_TAP5 = 3'd5
	} cfg_index_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	// symmetric low-pass gains in Q1.15
	localparam coef_t COEF_RESET [NUM_COEF_REGS] = '{
		16'sd333, 16'sd3857, 16'sd12194, 16'sd12194, 16'sd3857, 16'sd333
	};

endpackage

FILE: rtl/core/four_channel_fir_lowpass_unit.sv
// ----------------------------------------------------------------------------
// four_channel_fir_lowpass_unit
// Four-channel FIR low-pass filter with programmable Q1.15 coefficients.
// ----------------------------------------------------------------------------
// Takes one word of four signed samples per cycle and returns one word of four
// filtered samples per cycle while out_ready is high. Words pass the delay
// line register, then the output register; the per-channel multiply and adder
// tree between them sets the clock limit. Results are sum(coef * sample),
// rounded half up, shifted right by 15 and saturated. Delay lines clear at
// reset; coefficients reset to the symmetric low-pass gains. The user must
// write them through the cfg channel (index 0 is the newest tap) only while
// the unit is idle; the block does not check this. Other indexes are dropped.
module four_channel_fir_lowpass_unit #(
	parameter int TAP_COUNT    = 6,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_ch0,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_ch1,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_ch2,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample_ch3,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered_ch0,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered_ch1,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered_ch2,
	output logic signed [SAMPLE_WIDTH-1:0]        filtered_ch3,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fcfl_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fcfl_pkg::COEF_W-1:0]           cfg_data
);
	import fcfl_pkg::*;

	logic [TAP_COUNT-1:0][COEF_W-1:0] coef;
	logic signed [SAMPLE_WIDTH-1:0]   sample   [CHANNEL_COUNT];
	logic signed [SAMPLE_WIDTH-1:0]   filt     [CHANNEL_COUNT];
	logic signed [SAMPLE_WIDTH-1:0]   filt_q   [CHANNEL_COUNT];
	logic                             valid_s1;
	logic                             out_valid_q;
	logic                             advance;
	logic                             accept;

	assign cfg_ready = 1'b1;

	fcfl_coef_regs #(
		.TAP_COUNT (TAP_COUNT)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	assign sample[0] = sample_ch0;
	assign sample[1] = sample_ch1;
	assign sample[2] = sample_ch2;
	assign sample[3] = sample_ch3;

	// move stage 1 forward whenever the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
		fcfl_lane #(
			.TAP_COUNT    (TAP_COUNT),
			.SAMPLE_WIDTH (SAMPLE_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.sample   (sample[c]),
			.coef     (coef),
			.filtered (filt[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				filt_q[c] <= filt[c];
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_ch0 = filt_q[0];
	assign filtered_ch1 = filt_q[1];
	assign filtered_ch2 = filt_q[2];
	assign filtered_ch3 = filt_q[3];

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("stage 1 word did not move to the output register");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while the output register is empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full and stalled");
`endif

endmodule

FILE: rtl/core/fcfl_coef_regs.sv
// ----------------------------------------------------------------------------
// fcfl_coef_regs
// Coefficient register file; taps without a register read as zero.
// ----------------------------------------------------------------------------
module fcfl_coef_regs #(
	parameter int TAP_COUNT = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [fcfl_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [fcfl_pkg::COEF_W-1:0]           cfg_data,
	output logic [TAP_COUNT-1:0][fcfl_pkg::COEF_W-1:0] coef
);
	import fcfl_pkg::*;

	coef_t coef_q [NUM_COEF_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEF_REGS; k++) begin
				coef_q[k] <= COEF_RESET[k];
			end
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_COEF_TAP0: coef_q[0] <= cfg_data;
				CFG_COEF_TAP1: coef_q[1] <= cfg_data;
				CFG_COEF_TAP2: coef_q[2] <= cfg_data;
				CFG_COEF_TAP3: coef_q[3] <= cfg_data;
				CFG_COEF_TAP4: coef_q[4] <= cfg_data;
				CFG_COEF_TAP5: coef_q[5] <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
		if (i < NUM_COEF_REGS) begin : g_reg
			assign coef[i] = coef_q[i];
		end else begin : g_zero
			assign coef[i] = '0;
		end
	end

endmodule

FILE: rtl/core/fcfl_lane.sv
// ----------------------------------------------------------------------------
// fcfl_lane
// One channel: delay line register plus multiply-accumulate, round and clamp.
// ----------------------------------------------------------------------------
module fcfl_lane #(
	parameter int TAP_COUNT    = 6,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       shift_en,
	input  logic signed [SAMPLE_WIDTH-1:0]             sample,
	input  logic [TAP_COUNT-1:0][fcfl_pkg::COEF_W-1:0] coef,
	output logic signed [SAMPLE_WIDTH-1:0]             filtered
);
	import fcfl_pkg::*;

	localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
	localparam int Q_W    = ACC_W - FRAC_BITS;
	localparam logic signed [Q_W-1:0] MAXV =
		{{(Q_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [Q_W-1:0] MINV = ~MAXV;

	// tap 0 is the newest sample; the line doubles as the stage-1 register
	logic signed [SAMPLE_WIDTH-1:0] taps_s1 [TAP_COUNT];
	logic signed [PROD_W-1:0]       prod [TAP_COUNT];
	logic signed [ACC_W-1:0]        acc;
	logic signed [ACC_W-1:0]        rnd;
	logic signed [Q_W-1:0]          q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				taps_s1[i] <= '0;
			end
		end else if (shift_en) begin
			taps_s1[0] <= sample;
			for (int i = 1; i < TAP_COUNT; i++) begin
				taps_s1[i] <= taps_s1[i-1];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			prod[i] = taps_s1[i] * $signed(coef[i]);
			acc     = acc + ACC_W'(prod[i]);
		end
		rnd = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
		q   = $signed(rnd[ACC_W-1:FRAC_BITS]);
		priority if (q > MAXV) begin
			filtered = MAXV[SAMPLE_WIDTH-1:0];
		end else if (q < MINV) begin
			filtered = MINV[SAMPLE_WIDTH-1:0];
		end else begin
			filtered = q[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
